// File: rtl/core/hsbd_pkg.sv
// Package: widths, constants, types and helpers of the half-scale box downsampler.
package hsbd_pkg;

    localparam int MaxWidth   = 4096;
    localparam int RowLimit   = 4096;
    localparam int StoreDepth = MaxWidth / 2;
    localparam int AddrW      = $clog2(StoreDepth);
    localparam int CntW       = AddrW + 1;
    localparam int DimW       = 13;
    localparam int ChanW      = 8;
    localparam int SumW       = ChanW + 1;
    localparam int NumChan    = 4;
    localparam int PairW      = NumChan * SumW;
    localparam int CfgIdxW    = 1;

    // register indexes of the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef logic [NumChan-1:0][SumW-1:0] t_pair;

    // one emitting pixel handed from the front end to the output stage
    typedef struct packed {
        logic  valid;
        logic  use_above;
        logic  frame_end;
        t_pair pair;
    } t_issue;

    // last column/row index of a dimension: zero acts as one, large values clamp
    function automatic logic [CntW-1:0] last_index(input logic [DimW-1:0] v,
                                                   input logic [DimW-1:0] limit);
        logic [DimW-1:0] t;
        if (v == '0) begin
            t = DimW'(1);
        end else if (v > limit) begin
            t = limit;
        end else begin
            t = v;
        end
        last_index = CntW'(t - DimW'(1));
    endfunction

endpackage

// File: rtl/core/hsbd_if.sv
// Stream interfaces: input pixel channel and output pixel channel.
interface hsbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;

    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    output ready);
endinterface

interface hsbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       frame_end;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_alpha, output frame_end, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_alpha, input frame_end, output ready);
endinterface

// File: rtl/core/hsbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hsbd_ram #(
    parameter int Width = 36,
    parameter int Depth = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(Depth)-1:0] i_wr_addr,
    input  logic [Width-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(Depth)-1:0] i_rd_addr,
    output logic [Width-1:0]         o_rd_data
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/hsbd_front.sv
// Front end: configuration, raster counters, pair sums and line store access.
module hsbd_front
    import hsbd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [DimW-1:0]    i_cfg_data,
    hsbd_in_if.sink            i_pix,
    input  logic               i_take,
    output logic               o_wr_en,
    output logic [AddrW-1:0]   o_wr_addr,
    output logic [PairW-1:0]   o_wr_data,
    output logic               o_rd_en,
    output logic [AddrW-1:0]   o_rd_addr,
    output t_issue             o_issue
);

    logic [DimW-1:0] r_image_width;
    logic [DimW-1:0] r_image_height;
    logic [CntW-1:0] r_col, n_col;
    logic [CntW-1:0] r_row, n_row;
    t_pair           r_pair, n_pair;

    logic            acc;
    logic [CntW-1:0] col_last;
    logic [CntW-1:0] row_last;
    logic            last_col;
    logic            last_row;
    logic            pair_done;
    logic [NumChan-1:0][ChanW-1:0] pix;

    assign i_pix.ready = i_take;
    assign acc         = i_pix.valid && i_take;

    assign pix[0] = i_pix.red;
    assign pix[1] = i_pix.green;
    assign pix[2] = i_pix.blue;
    assign pix[3] = i_pix.alpha;

    assign col_last  = last_index(r_image_width, DimW'(MaxWidth));
    assign row_last  = last_index(r_image_height, DimW'(RowLimit));
    assign last_col  = r_col >= col_last;
    assign last_row  = r_row >= row_last;
    assign pair_done = r_col[0] || last_col;

    always_comb begin
        for (int c = 0; c < NumChan; c++) begin
            if (r_col[0]) begin
                n_pair[c] = r_pair[c] + {1'b0, pix[c]};
            end else begin
                n_pair[c] = {1'b0, pix[c]};
            end
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (acc) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + CntW'(1);
            end else begin
                n_col = r_col + CntW'(1);
            end
        end
    end

    // even rows park the pair in the store; odd rows and a lone last row emit
    assign o_wr_en   = acc && pair_done && !r_row[0] && !last_row;
    assign o_wr_addr = r_col[CntW-1:1];
    assign o_wr_data = n_pair;
    assign o_rd_en   = acc && pair_done && r_row[0];
    assign o_rd_addr = r_col[CntW-1:1];

    assign o_issue.valid     = acc && pair_done && (r_row[0] || last_row);
    assign o_issue.use_above = r_row[0];
    assign o_issue.frame_end = last_col && last_row;
    assign o_issue.pair      = n_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= DimW'(1);
            r_image_height <= DimW'(1);
            r_col          <= '0;
            r_row          <= '0;
            r_pair         <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_IMAGE_WIDTH) begin
                    r_image_width <= i_cfg_data;
                end
                if (i_cfg_idx == REG_IMAGE_HEIGHT) begin
                    r_image_height <= i_cfg_data;
                end
            end
            r_col <= n_col;
            r_row <= n_row;
            if (acc) begin
                r_pair <= n_pair;
            end
        end
    end

endmodule

// File: rtl/core/hsbd_back.sv
// Output stage: joins the stored pair with the current one and holds the result.
module hsbd_back
    import hsbd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_issue           i_issue,
    input  logic [PairW-1:0] i_rd_data,
    output logic             o_take,
    hsbd_out_if.source       o_pix
);

    logic   r_s1_valid;
    t_issue r_s1;
    logic   r_out_valid;
    logic   r_frame_end;
    logic [NumChan-1:0][ChanW-1:0] r_avg, n_avg;

    logic   s1_move;
    t_pair  above;

    assign s1_move = r_s1_valid && (!r_out_valid || o_pix.ready);
    assign o_take  = !r_s1_valid || s1_move;
    assign above   = i_rd_data;

    always_comb begin
        for (int c = 0; c < NumChan; c++) begin
            logic [SumW:0] sum;
            sum = {1'b0, r_s1.pair[c]};
            if (r_s1.use_above) begin
                sum = sum + {1'b0, above[c]};
            end
            n_avg[c] = sum[SumW:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_s1_valid <= i_issue.valid;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // read data for the item in s1 arrives from the store in the cycle after issue
    always_ff @(posedge i_clk) begin
        if (o_take && i_issue.valid) begin
            r_s1 <= i_issue;
        end
        if (s1_move) begin
            r_avg       <= n_avg;
            r_frame_end <= r_s1.frame_end;
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.out_red   = r_avg[0];
    assign o_pix.out_green = r_avg[1];
    assign o_pix.out_blue  = r_avg[2];
    assign o_pix.out_alpha = r_avg[3];
    assign o_pix.frame_end = r_frame_end;

endmodule

// File: rtl/core/half_scale_box_downsampler.sv
// Top level of the half-scale 2x2 box downsampler.
// Accepts RGBA pixels in raster order, one per clock while the output is ready, and
// emits the half-size image in raster order, one output for every 2x2 block: the
// per-channel sum divided by 4, truncated, with pixels beyond the right or bottom
// edge counted as zero. A result is registered in s1, then in the output register.
// Horizontal pair sums of each even row are kept in a 2048 x 36-bit line store (one
// write port, one registered read port), read back during the following odd row.
// The last output pixel of a frame carries frame_end. Width and height (1..4096)
// must be written through the configuration port while the block is idle; the block
// does not enforce this. 0 acts as 1 and larger values clamp to 4096.
module half_scale_box_downsampler
    import hsbd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [DimW-1:0]    i_cfg_data,
    hsbd_in_if.sink            i_pix,
    hsbd_out_if.source         o_pix
);

    logic             take;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [PairW-1:0] wr_data;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic [PairW-1:0] rd_data;
    t_issue           issue;

    hsbd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_take     (take),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_issue    (issue)
    );

    hsbd_ram #(
        .Width (PairW),
        .Depth (StoreDepth)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    hsbd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_issue   (issue),
        .i_rd_data (rd_data),
        .o_take    (take),
        .o_pix     (o_pix)
    );

endmodule

// File: test/tb_half_scale_box_downsampler.sv
// Self-checking testbench for the half-scale 2x2 box downsampler.
module tb_half_scale_box_downsampler;
    import hsbd_pkg::*;

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] alpha;
    } t_rgba;

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] alpha;
        logic             frame_end;
    } t_avg_px;

    // Tracks the block's counters, pair sums and line store; queues the averages
    // that accepted pixels produce and matches them against the output stream.
    class block_avg_board;
        logic [DimW-1:0] width_reg;
        logic [DimW-1:0] height_reg;
        logic [11:0]     col;
        logic [11:0]     row;
        t_pair           run_pair;
        t_pair           even_row_pairs [StoreDepth];
        t_avg_px         pending_avgs [$];
        int unsigned     pixels_in;
        int unsigned     avgs_checked;
        int unsigned     frame_ends;
        int unsigned     cfg_writes;
        int unsigned     mismatches;

        function new();
            width_reg    = DimW'(1);
            height_reg   = DimW'(1);
            col          = '0;
            row          = '0;
            run_pair     = '0;
            pixels_in    = 0;
            avgs_checked = 0;
            frame_ends   = 0;
            cfg_writes   = 0;
            mismatches   = 0;
        endfunction

        function int unsigned eff_dim(logic [DimW-1:0] v, int unsigned limit);
            if (v == '0) return 1;
            if (v > limit) return limit;
            return v;
        endfunction

        function void write_reg(t_cfg_reg r, logic [DimW-1:0] v);
            case (r)
                REG_IMAGE_WIDTH:  width_reg  = v;
                REG_IMAGE_HEIGHT: height_reg = v;
                default: ;
            endcase
            cfg_writes++;
        endfunction

        function void take_pixel(t_rgba p);
            int unsigned      w;
            int unsigned      h;
            int unsigned      idx;
            logic             last_col;
            logic             last_row;
            logic [ChanW-1:0] ch [NumChan];
            t_pair            above;
            logic [ChanW-1:0] q [NumChan];
            t_avg_px          avg;
            w        = eff_dim(width_reg, MaxWidth);
            h        = eff_dim(height_reg, RowLimit);
            last_col = (col >= w - 1);
            last_row = (row >= h - 1);
            idx      = col >> 1;
            ch[0] = p.red;
            ch[1] = p.green;
            ch[2] = p.blue;
            ch[3] = p.alpha;
            for (int c = 0; c < NumChan; c++) begin
                if (!col[0]) begin
                    run_pair[c] = {1'b0, ch[c]};
                end else begin
                    run_pair[c] = run_pair[c] + ch[c];
                end
            end
            if (col[0] || last_col) begin
                if (!row[0] && !last_row) begin
                    even_row_pairs[idx] = run_pair;
                end else begin
                    // bottom row of an odd-height frame has nothing stored above it
                    above = row[0] ? even_row_pairs[idx] : '0;
                    for (int c = 0; c < NumChan; c++) begin
                        q[c] = ChanW'((10'(above[c]) + 10'(run_pair[c])) >> 2);
                    end
                    avg.red       = q[0];
                    avg.green     = q[1];
                    avg.blue      = q[2];
                    avg.alpha     = q[3];
                    avg.frame_end = last_col && last_row;
                    pending_avgs.push_back(avg);
                end
            end
            if (last_col) begin
                col = '0;
                row = last_row ? 12'd0 : row + 12'd1;
            end else begin
                col = col + 12'd1;
            end
            pixels_in++;
        endfunction

        function void match_avg(t_avg_px got);
            t_avg_px want;
            if (pending_avgs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: output transaction with nothing pending: %h %h %h %h fe=%b",
                             $realtime, got.red, got.green, got.blue, got.alpha,
                             got.frame_end);
                return;
            end
            want = pending_avgs.pop_front();
            avgs_checked++;
            if (got.frame_end === 1'b1) frame_ends++;
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.alpha !== want.alpha ||
                got.frame_end !== want.frame_end) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: avg #%0d rgba exp %h %h %h %h fe=%b, got %h %h %h %h fe=%b",
                             $realtime, avgs_checked, want.red, want.green, want.blue,
                             want.alpha, want.frame_end, got.red, got.green, got.blue,
                             got.alpha, got.frame_end);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_idx;
    logic [DimW-1:0]    i_cfg_data;

    hsbd_in_if  pix_in ();
    hsbd_out_if pix_out ();

    block_avg_board board;
    bit             calm;
    int unsigned    ready_hold;

    half_scale_box_downsampler uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    always #5 i_clk = ~i_clk;

    // output back-pressure: short stalls mostly, a few long ones, none while calm
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
            ready_hold    <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (calm || !pix_out.ready) begin
            pix_out.ready <= 1'b1;
            ready_hold    <= $urandom_range(0, 40);
        end else begin
            pix_out.ready <= 1'b0;
            ready_hold    <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                          : $urandom_range(7, 29);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && pix_out.valid === 1'b1 && pix_out.ready === 1'b1)
            board.match_avg({pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                             pix_out.out_alpha, pix_out.frame_end});
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [ChanW-1:0] pick_chan();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return ChanW'($urandom);
    endfunction

    function automatic t_rgba random_pixel();
        t_rgba p;
        p.red   = pick_chan();
        p.green = pick_chan();
        p.blue  = pick_chan();
        p.alpha = pick_chan();
        return p;
    endfunction

    task automatic send_pixel(input t_rgba p);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.red   <= p.red;
        pix_in.green <= p.green;
        pix_in.blue  <= p.blue;
        pix_in.alpha <= p.alpha;
        do @(posedge i_clk); while (!(pix_in.valid === 1'b1 && pix_in.ready === 1'b1));
        board.take_pixel(p);
    endtask

    task automatic send_pixels(input int unsigned n);
        repeat (n) send_pixel(random_pixel());
    endtask

    // fixed corner values: saturated, zero and alternating channels
    task automatic send_pattern(input int unsigned n);
        t_rgba p;
        for (int unsigned i = 0; i < n; i++) begin
            p.red   = (i % 2 != 0) ? 8'h00 : 8'hFF;
            p.green = (i % 3 == 0) ? 8'hFF : 8'h00;
            p.blue  = ChanW'(i * 37 + 8'hAA);
            p.alpha = ~ChanW'(i * 37 + 8'hAA);
            send_pixel(p);
        end
    endtask

    // after a mid-frame resize, run on until the counters wrap to a frame start
    task automatic finish_frame();
        while (board.col != 0 || board.row != 0) send_pixel(random_pixel());
    endtask

    task automatic drain(input int unsigned settle);
        pix_in.valid <= 1'b0;
        while (board.pending_avgs.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [DimW-1:0] w, input logic [DimW-1:0] h);
        drain(8);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_IMAGE_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        board.write_reg(REG_IMAGE_WIDTH, w);
        i_cfg_idx  <= REG_IMAGE_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        board.write_reg(REG_IMAGE_HEIGHT, h);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [DimW-1:0] pick_width();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return DimW'($urandom_range(1, 16));
        if (r < 88) return DimW'($urandom_range(17, 64));
        if (r < 94) return '0;
        return DimW'($urandom_range(65, 300));
    endfunction

    function automatic logic [DimW-1:0] pick_height();
        if ($urandom_range(0, 19) == 0) return '0;
        return DimW'($urandom_range(1, 9));
    endfunction

    initial begin
        logic [DimW-1:0] w;
        logic [DimW-1:0] h;
        int unsigned     n;
        int unsigned     start_px;
        board = new();
        calm  = 1'b0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= REG_IMAGE_WIDTH;
        i_cfg_data   <= '0;
        pix_in.valid <= 1'b0;
        pix_in.red   <= '0;
        pix_in.green <= '0;
        pix_in.blue  <= '0;
        pix_in.alpha <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset size 1x1, zero size, full 2x2, odd width and height, one row
        send_pattern(1);
        set_dims('0, '0);
        send_pattern(1);
        set_dims(DimW'(2), DimW'(2));
        send_pattern(4);
        set_dims(DimW'(3), DimW'(3));
        send_pattern(9);
        set_dims(DimW'(5), DimW'(1));
        send_pattern(5);

        // wide two-row frame writes every line store entry the random frames can reach
        calm = 1'b1;
        set_dims(DimW'(320), DimW'(2));
        send_pixels(640);
        calm = 1'b0;

        // oversized register values, cut short by a resize
        set_dims(DimW'(8191), DimW'(8191));
        send_pixels(48);
        set_dims(DimW'(6), DimW'(3));
        finish_frame();

        start_px = board.pixels_in;
        while (board.pixels_in - start_px < 900) begin
            w = pick_width();
            h = pick_height();
            if (board.eff_dim(w, MaxWidth) > 64) h = DimW'($urandom_range(1, 2));
            calm = ($urandom_range(0, 4) == 0);
            set_dims(w, h);
            n = board.eff_dim(w, MaxWidth) * board.eff_dim(h, RowLimit);
            if (n > 1 && $urandom_range(0, 7) == 0) begin
                // broken frame: resize partway through
                send_pixels($urandom_range(1, n - 1));
                set_dims(pick_width() % DimW'(40), pick_height());
                finish_frame();
            end else begin
                send_pixels(n);
            end
        end

        calm = 1'b0;
        drain(16);
        $display("Sent %0d pixels through %0d register writes;",
                 board.pixels_in, board.cfg_writes);
        $display("checked %0d averages, %0d frame ends.",
                 board.avgs_checked, board.frame_ends);
        $display("Mismatches: %0d", board.mismatches);
        if (board.mismatches == 0) begin
            $display("tb_half_scale_box_downsampler OK");
        end else begin
            $display("tb_half_scale_box_downsampler NOT OK");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Timeout with %0d averages still pending", board.pending_avgs.size());
        $display("tb_half_scale_box_downsampler NOT OK");
        $finish;
    end

endmodule
